// ===== design/rfp_pkg.sv =====
// shared types and constants for the request frame parser
`default_nettype none
package rfp_pkg;

  localparam int LINE_LIMIT_DEF = 256;
  localparam int LEN_WIDTH_DEF  = 16;
  localparam int MAX_ARGS       = 64;

  localparam int ID_LIM_W  = 8;
  localparam int ARG_LIM_W = 16;
  localparam int ARGC_W    = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 4;
  localparam int FLEN_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ID_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARGC_LIMIT = 2'd2;

  localparam logic [ID_LIM_W-1:0]  ID_LIMIT_RST   = 8'd64;
  localparam logic [ARG_LIM_W-1:0] ARG_LIMIT_RST  = 16'd4096;
  localparam logic [ARGC_W-1:0]    ARGC_LIMIT_RST = 6'd63;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_R     = 8'h52;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_ARG    = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    KS_START    = 4'd0,
    KS_I        = 4'd1,
    KS_ID       = 4'd2,
    KS_A        = 4'd3,
    KS_AR       = 4'd4,
    KS_ARG      = 4'd5,
    KS_ARGC     = 4'd6,
    KS_E        = 4'd7,
    KS_EN       = 4'd8,
    KS_END      = 4'd9,
    KS_NUM_ID   = 4'd10,
    KS_NUM_ARGC = 4'd11,
    KS_NUM_ARG  = 4'd12,
    KS_BAD      = 4'd13
  } kw_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ID_HDR  = 3'd0,
    KIND_ARG_HDR = 3'd1,
    KIND_ID_BYTE = 3'd2,
    KIND_ARG_BYTE = 3'd3,
    KIND_VERDICT = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 4'd0,
    ST_CLOSED        = 4'd1,
    ST_LINE_LONG     = 4'd2,
    ST_ID_RANGE      = 4'd3,
    ST_SHORT_ID      = 4'd4,
    ST_DUP_ARGC      = 4'd5,
    ST_ARGC_RANGE    = 4'd6,
    ST_ARG_NO_ARGC   = 4'd7,
    ST_ARG_EXCESS    = 4'd8,
    ST_ARG_RANGE     = 4'd9,
    ST_SHORT_ARG     = 4'd10,
    ST_UNKNOWN_LINE  = 4'd11,
    ST_END_NO_ARGC   = 4'd12,
    ST_ARGC_MISMATCH = 4'd13
  } status_t;

endpackage
`default_nettype wire

// ===== design/request_frame_parser_unit.sv =====
// request frame parser: header line scanner, payload pass-through and verdicts
//
// Input channel (in_valid / in_ready) carries one stream byte per transfer, or
// an end-of-stream marker. Each transfer yields zero or one result on the
// output channel (out_valid / out_ready): a frame header, a payload byte, or a
// request verdict. Header text and the ARGC line give no result.
// The result of a byte sits in the output register on the cycle after its
// transfer. Throughput is one byte per cycle while in_ready stays high; the
// parser state is updated in the same cycle the byte is taken, so the keyword
// decode, the decimal accumulate and the limit compares set the clock path.
// in_ready is high whenever the output register is empty or is being drained
// in the same cycle, so a stalled receiver holds off only the next byte.
// Configuration (cfg_write_en, cfg_index, cfg_data) writes the three limits;
// write only while no transfer is in flight.
// Reset (rst_n low, synchronous) starts a new request, empties the output
// register and loads the default limits. After any verdict the next byte
// starts a new request; the limits keep their values.
`default_nettype none
module request_frame_parser_unit #(
  parameter int LINE_LIMIT = rfp_pkg::LINE_LIMIT_DEF,
  parameter int LEN_WIDTH  = rfp_pkg::LEN_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_en,
  input  wire logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rfp_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_end_of_stream,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rfp_pkg::KIND_W-1:0]          out_kind,
  output logic [rfp_pkg::ARGC_W-1:0]          out_arg_index,
  output logic [rfp_pkg::FLEN_W-1:0]          out_frame_length,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_last_of_frame,
  output logic [rfp_pkg::STATUS_W-1:0]        out_status
);
  import rfp_pkg::*;

  localparam int LCW = $clog2(LINE_LIMIT);
  localparam int NW  = LEN_WIDTH + 1;
  localparam int CW  = (NW > 16) ? NW : 16;
  localparam logic [NW-1:0]  NUM_SAT  = {NW{1'b1}};
  localparam logic [LCW:0]   LINE_TOP = (LCW+1)'(LINE_LIMIT);
  localparam logic [CW-1:0]  ARGS_TOP = CW'(MAX_ARGS - 1);

  // configuration
  logic [ID_LIM_W-1:0]  id_lim_r;
  logic [ARG_LIM_W-1:0] arg_lim_r;
  logic [ARGC_W-1:0]    argc_lim_r;

  // request state
  phase_t              phase_r, phase_nxt;
  logic [LCW-1:0]      line_count_r, line_count_nxt;
  kw_t                 kw_r, kw_nxt;
  logic                text_ended_r, text_ended_nxt;
  logic [NW-1:0]       num_r, num_nxt;
  logic                num_bad_r, num_bad_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                announced_r, announced_nxt;
  logic [ARGC_W-1:0]   ann_count_r, ann_count_nxt;
  logic [ARGC_W-1:0]   frames_r, frames_nxt;
  logic [NW-1:0]       pay_left_r, pay_left_nxt;

  // output register
  logic                out_valid_r;
  kind_t               res_kind_r;
  logic [ARGC_W-1:0]   res_idx_r;
  logic [FLEN_W-1:0]   res_len_r;
  logic [7:0]          res_byte_r;
  logic                res_last_r;
  status_t             res_status_r;

  // decode results
  logic                in_xfer;
  logic                dec_emit;
  logic                dec_verdict;
  kind_t               dec_kind;
  status_t             dec_status;
  logic                in_payload;
  logic                is_nl;
  logic                is_digit;
  logic                pay_last;
  logic                ok_num;
  logic [CW-1:0]       num_cmp;
  logic [LCW:0]        lc_inc;
  logic [NW+3:0]       num_x10;
  logic [NW-1:0]       num_acc;
  kw_t                 kw_step;

  assign in_ready   = !out_valid_r || out_ready;
  assign in_xfer    = in_valid && in_ready;
  assign in_payload = (phase_r != PH_HEADER);
  assign is_nl      = (in_data_byte == CH_NL);
  assign is_digit   = in_data_byte inside {[CH_ZERO:CH_NINE]};
  assign pay_last   = (pay_left_r <= NW'(1));
  assign ok_num     = digit_seen_r && !num_bad_r;
  assign num_cmp    = CW'(num_r);
  assign lc_inc     = (LCW+1)'(line_count_r) + (LCW+1)'(1);

  // decimal accumulate with saturation
  assign num_x10 = ((NW+4)'(num_r) << 3) + ((NW+4)'(num_r) << 1)
                 + (NW+4)'(in_data_byte - CH_ZERO);
  assign num_acc = (num_x10[NW+3:NW] != 4'd0) ? NUM_SAT : num_x10[NW-1:0];

  // keyword scanner step
  always_comb begin
    kw_step = KS_BAD;
    case (kw_r)
      KS_START: begin
        if (in_data_byte == CH_I) kw_step = KS_I;
        else if (in_data_byte == CH_A) kw_step = KS_A;
        else if (in_data_byte == CH_E) kw_step = KS_E;
      end
      KS_I:    if (in_data_byte == CH_D) kw_step = KS_ID;
      KS_ID:   if (in_data_byte == CH_SPACE) kw_step = KS_NUM_ID;
      KS_A:    if (in_data_byte == CH_R) kw_step = KS_AR;
      KS_AR:   if (in_data_byte == CH_G) kw_step = KS_ARG;
      KS_ARG: begin
        if (in_data_byte == CH_C) kw_step = KS_ARGC;
        else if (in_data_byte == CH_SPACE) kw_step = KS_NUM_ARG;
      end
      KS_ARGC: if (in_data_byte == CH_SPACE) kw_step = KS_NUM_ARGC;
      KS_E:    if (in_data_byte == CH_N) kw_step = KS_EN;
      KS_EN:   if (in_data_byte == CH_D) kw_step = KS_END;
      KS_NUM_ID, KS_NUM_ARGC, KS_NUM_ARG: kw_step = kw_r;
      default: kw_step = KS_BAD;
    endcase
  end

  // per-byte decision: what result, if any, and whether the request ends
  always_comb begin
    dec_emit    = 1'b0;
    dec_verdict = 1'b0;
    dec_kind    = KIND_VERDICT;
    dec_status  = ST_OK;
    if (in_payload) begin
      if (in_end_of_stream) begin
        dec_verdict = 1'b1;
        dec_status  = (phase_r == PH_ID) ? ST_SHORT_ID : ST_SHORT_ARG;
      end else begin
        dec_emit = 1'b1;
        dec_kind = (phase_r == PH_ID) ? KIND_ID_BYTE : KIND_ARG_BYTE;
      end
    end else if (in_end_of_stream) begin
      dec_verdict = 1'b1;
      dec_status  = ST_CLOSED;
    end else if (is_nl) begin
      case (kw_r)
        KS_NUM_ID: begin
          if (!ok_num || num_cmp > CW'(id_lim_r)) begin
            dec_verdict = 1'b1;
            dec_status  = ST_ID_RANGE;
          end else begin
            dec_emit = 1'b1;
            dec_kind = KIND_ID_HDR;
          end
        end
        KS_NUM_ARGC: begin
          if (announced_r) begin
            dec_verdict = 1'b1;
            dec_status  = ST_DUP_ARGC;
          end else if (!ok_num || num_cmp == CW'(0) || num_cmp > CW'(argc_lim_r)
                       || num_cmp > ARGS_TOP) begin
            dec_verdict = 1'b1;
            dec_status  = ST_ARGC_RANGE;
          end
        end
        KS_NUM_ARG: begin
          if (!announced_r) begin
            dec_verdict = 1'b1;
            dec_status  = ST_ARG_NO_ARGC;
          end else if (frames_r >= ann_count_r) begin
            dec_verdict = 1'b1;
            dec_status  = ST_ARG_EXCESS;
          end else if (!ok_num || num_cmp > CW'(arg_lim_r)) begin
            dec_verdict = 1'b1;
            dec_status  = ST_ARG_RANGE;
          end else begin
            dec_emit = 1'b1;
            dec_kind = KIND_ARG_HDR;
          end
        end
        KS_END: begin
          dec_verdict = 1'b1;
          if (!announced_r) dec_status = ST_END_NO_ARGC;
          else if (frames_r != ann_count_r) dec_status = ST_ARGC_MISMATCH;
          else dec_status = ST_OK;
        end
        default: begin
          dec_verdict = 1'b1;
          dec_status  = ST_UNKNOWN_LINE;
        end
      endcase
    end else if (lc_inc >= LINE_TOP) begin
      dec_verdict = 1'b1;
      dec_status  = ST_LINE_LONG;
    end
    if (dec_verdict) dec_emit = 1'b1;
  end

  // next request state
  always_comb begin
    phase_nxt      = phase_r;
    line_count_nxt = line_count_r;
    kw_nxt         = kw_r;
    text_ended_nxt = text_ended_r;
    num_nxt        = num_r;
    num_bad_nxt    = num_bad_r;
    digit_seen_nxt = digit_seen_r;
    announced_nxt  = announced_r;
    ann_count_nxt  = ann_count_r;
    frames_nxt     = frames_r;
    pay_left_nxt   = pay_left_r;
    if (in_xfer) begin
      if (dec_verdict) begin
        phase_nxt      = PH_HEADER;
        line_count_nxt = '0;
        kw_nxt         = KS_START;
        text_ended_nxt = 1'b0;
        num_nxt        = '0;
        num_bad_nxt    = 1'b0;
        digit_seen_nxt = 1'b0;
        announced_nxt  = 1'b0;
        ann_count_nxt  = '0;
        frames_nxt     = '0;
        pay_left_nxt   = '0;
      end else if (in_payload) begin
        if (pay_last) begin
          pay_left_nxt = '0;
          phase_nxt    = PH_HEADER;
          if (phase_r == PH_ARG) frames_nxt = frames_r + ARGC_W'(1);
        end else begin
          pay_left_nxt = pay_left_r - NW'(1);
        end
      end else if (is_nl) begin
        // a header line that passed its checks
        line_count_nxt = '0;
        kw_nxt         = KS_START;
        text_ended_nxt = 1'b0;
        num_nxt        = '0;
        num_bad_nxt    = 1'b0;
        digit_seen_nxt = 1'b0;
        if (kw_r == KS_NUM_ARGC) begin
          announced_nxt = 1'b1;
          ann_count_nxt = num_r[ARGC_W-1:0];
        end else if (num_r != '0) begin
          phase_nxt    = (kw_r == KS_NUM_ID) ? PH_ID : PH_ARG;
          pay_left_nxt = num_r;
        end else if (kw_r == KS_NUM_ARG) begin
          frames_nxt = frames_r + ARGC_W'(1);
        end
      end else begin
        line_count_nxt = lc_inc[LCW-1:0];
        if (!text_ended_r) begin
          if (in_data_byte == CH_NUL) begin
            text_ended_nxt = 1'b1;
          end else begin
            kw_nxt = kw_step;
            if (kw_r == KS_NUM_ID || kw_r == KS_NUM_ARGC || kw_r == KS_NUM_ARG) begin
              if (is_digit) begin
                num_nxt        = num_acc;
                digit_seen_nxt = 1'b1;
              end else begin
                num_bad_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_lim_r   <= ID_LIMIT_RST;
      arg_lim_r  <= ARG_LIMIT_RST;
      argc_lim_r <= ARGC_LIMIT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ID_LIMIT:   id_lim_r   <= cfg_data[ID_LIM_W-1:0];
        REG_ARG_LIMIT:  arg_lim_r  <= cfg_data[ARG_LIM_W-1:0];
        REG_ARGC_LIMIT: argc_lim_r <= cfg_data[ARGC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      line_count_r <= '0;
      kw_r         <= KS_START;
      text_ended_r <= 1'b0;
      num_r        <= '0;
      num_bad_r    <= 1'b0;
      digit_seen_r <= 1'b0;
      announced_r  <= 1'b0;
      ann_count_r  <= '0;
      frames_r     <= '0;
      pay_left_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      line_count_r <= line_count_nxt;
      kw_r         <= kw_nxt;
      text_ended_r <= text_ended_nxt;
      num_r        <= num_nxt;
      num_bad_r    <= num_bad_nxt;
      digit_seen_r <= digit_seen_nxt;
      announced_r  <= announced_nxt;
      ann_count_r  <= ann_count_nxt;
      frames_r     <= frames_nxt;
      pay_left_r   <= pay_left_nxt;
      if (in_xfer) out_valid_r <= dec_emit;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result fields, zero where the kind does not use them
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_kind_r   <= dec_kind;
      res_status_r <= dec_status;
      res_idx_r    <= '0;
      res_len_r    <= '0;
      res_byte_r   <= '0;
      res_last_r   <= 1'b0;
      case (dec_kind)
        KIND_ID_HDR:  res_len_r <= FLEN_W'(num_r[LEN_WIDTH-1:0]);
        KIND_ARG_HDR: begin
          res_idx_r <= frames_r;
          res_len_r <= FLEN_W'(num_r[LEN_WIDTH-1:0]);
        end
        KIND_ID_BYTE: begin
          res_byte_r <= in_data_byte;
          res_last_r <= pay_last;
        end
        KIND_ARG_BYTE: begin
          res_idx_r  <= frames_r;
          res_byte_r <= in_data_byte;
          res_last_r <= pay_last;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_kind_r;
  assign out_arg_index     = res_idx_r;
  assign out_frame_length  = res_len_r;
  assign out_payload_byte  = res_byte_r;
  assign out_last_of_frame = res_last_r;
  assign out_status        = res_status_r;

  a_payload_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (pay_left_r != '0))
    else $error("payload phase with nothing left");

  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= ann_count_r)
    else $error("more frames received than announced");

  a_no_frames_before_argc: assert property (@(posedge clk) disable iff (!rst_n)
    !announced_r |-> (frames_r == '0))
    else $error("frames counted without an announced count");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && dec_verdict) |=> (phase_r == PH_HEADER && !announced_r
                                  && line_count_r == '0 && out_valid_r))
    else $error("verdict did not start a new request");

  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_kind_r == KIND_VERDICT) |->
      (res_idx_r == '0 && res_len_r == '0 && !res_last_r))
    else $error("verdict carries frame fields");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the request frame parser: queued stream driver, result monitor, predictor
`timescale 1ns / 1ps
module tb;
  import rfp_pkg::*;

  localparam int NUM_SAT   = (1 << 17) - 1;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_item_t;

  typedef struct {
    kind_t       kind;
    logic [5:0]  idx;
    logic [15:0] flen;
    logic [7:0]  pbyte;
    logic        last;
    status_t     status;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ID_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'd0;
  logic in_end_of_stream = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [ARGC_W-1:0] out_arg_index;
  logic [FLEN_W-1:0] out_frame_length;
  logic [7:0] out_payload_byte;
  logic out_last_of_frame;
  logic [STATUS_W-1:0] out_status;

  request_frame_parser_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_arg_index     (out_arg_index),
    .out_frame_length  (out_frame_length),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status)
  );

  always #6 clk = ~clk;

  stream_item_t  stream_bytes[$];
  stream_item_t  staged[$];
  frame_result_t frame_results_due[$];
  int bytes_queued = 0;
  int mismatches = 0;
  logic in_xfer = 1'b0;
  int stall_requests = 0;

  // limit registers as the parser should hold them
  logic [7:0]  id_lim;
  logic [15:0] arg_lim;
  logic [5:0]  argc_lim;

  // parser state
  phase_t      req_phase;
  kw_t         keyword;
  int          line_len;
  bit          text_done;
  logic [16:0] num_acc;
  bit          num_bad;
  bit          digit_seen;
  bit          argc_seen;
  logic [5:0]  argc_announced;
  logic [5:0]  frames_done;
  logic [15:0] payload_left;

  logic [7:0] keyword_chars [12] = '{CH_I, CH_D, CH_A, CH_R, CH_G, CH_C, CH_E, CH_N,
                                     CH_SPACE, CH_ZERO, CH_NINE, CH_NUL};

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_line();
    line_len = 0;
    keyword = KS_START;
    text_done = 0;
    num_acc = '0;
    num_bad = 0;
    digit_seen = 0;
  endtask

  task automatic clear_request();
    req_phase = PH_HEADER;
    clear_line();
    argc_seen = 0;
    argc_announced = '0;
    frames_done = '0;
    payload_left = '0;
  endtask

  task automatic push_result(kind_t k, logic [5:0] idx, logic [15:0] flen, logic [7:0] b,
                             logic last, status_t st);
    frame_result_t r;
    r.kind = k;
    r.idx = idx;
    r.flen = flen;
    r.pbyte = b;
    r.last = last;
    r.status = st;
    frame_results_due.push_back(r);
  endtask

  task automatic push_verdict(status_t st);
    push_result(KIND_VERDICT, 6'd0, 16'd0, 8'd0, 1'b0, st);
    clear_request();
  endtask

  task automatic scan_text(logic [7:0] c);
    int v;
    case (keyword)
      KS_START: keyword = (c == CH_I) ? KS_I : (c == CH_A) ? KS_A : (c == CH_E) ? KS_E : KS_BAD;
      KS_I:     keyword = (c == CH_D) ? KS_ID : KS_BAD;
      KS_ID:    keyword = (c == CH_SPACE) ? KS_NUM_ID : KS_BAD;
      KS_A:     keyword = (c == CH_R) ? KS_AR : KS_BAD;
      KS_AR:    keyword = (c == CH_G) ? KS_ARG : KS_BAD;
      KS_ARG:   keyword = (c == CH_C) ? KS_ARGC : (c == CH_SPACE) ? KS_NUM_ARG : KS_BAD;
      KS_ARGC:  keyword = (c == CH_SPACE) ? KS_NUM_ARGC : KS_BAD;
      KS_E:     keyword = (c == CH_N) ? KS_EN : KS_BAD;
      KS_EN:    keyword = (c == CH_D) ? KS_END : KS_BAD;
      KS_NUM_ID, KS_NUM_ARGC, KS_NUM_ARG: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          // accumulator saturates so oversize counts fail every limit
          v = int'(num_acc) * 10 + int'(c - CH_ZERO);
          num_acc = (v > NUM_SAT) ? 17'(NUM_SAT) : 17'(v);
          digit_seen = 1;
        end else begin
          num_bad = 1;
        end
      end
      default: keyword = KS_BAD;
    endcase
  endtask

  task automatic finish_line();
    bit num_ok;
    int v;
    num_ok = digit_seen && !num_bad;
    v = int'(num_acc);
    case (keyword)
      KS_NUM_ID: begin
        if (!num_ok || v > id_lim) begin
          push_verdict(ST_ID_RANGE);
        end else begin
          push_result(KIND_ID_HDR, 6'd0, 16'(v), 8'd0, 1'b0, ST_OK);
          clear_line();
          if (v > 0) begin
            req_phase = PH_ID;
            payload_left = 16'(v);
          end
        end
      end
      KS_NUM_ARGC: begin
        if (argc_seen) push_verdict(ST_DUP_ARGC);
        else if (!num_ok || v < 1 || v > argc_lim || v > MAX_ARGS - 1) push_verdict(ST_ARGC_RANGE);
        else begin
          argc_seen = 1;
          argc_announced = 6'(v);
          clear_line();
        end
      end
      KS_NUM_ARG: begin
        if (!argc_seen) push_verdict(ST_ARG_NO_ARGC);
        else if (frames_done >= argc_announced) push_verdict(ST_ARG_EXCESS);
        else if (!num_ok || v > arg_lim) push_verdict(ST_ARG_RANGE);
        else begin
          push_result(KIND_ARG_HDR, frames_done, 16'(v), 8'd0, 1'b0, ST_OK);
          clear_line();
          // zero-length frame counts as received at its header
          if (v > 0) begin
            req_phase = PH_ARG;
            payload_left = 16'(v);
          end else begin
            frames_done++;
          end
        end
      end
      KS_END: begin
        if (!argc_seen) push_verdict(ST_END_NO_ARGC);
        else if (frames_done != argc_announced) push_verdict(ST_ARGC_MISMATCH);
        else push_verdict(ST_OK);
      end
      default: push_verdict(ST_UNKNOWN_LINE);
    endcase
  endtask

  task automatic parse_stream_item(logic [7:0] c, logic eos);
    bit is_id;
    bit last;
    if (req_phase != PH_HEADER) begin
      is_id = (req_phase == PH_ID);
      if (eos) begin
        push_verdict(is_id ? ST_SHORT_ID : ST_SHORT_ARG);
      end else begin
        last = (payload_left <= 16'd1);
        push_result(is_id ? KIND_ID_BYTE : KIND_ARG_BYTE, is_id ? 6'd0 : frames_done,
                    16'd0, c, last, ST_OK);
        if (last) begin
          payload_left = '0;
          req_phase = PH_HEADER;
          if (!is_id) frames_done++;
        end else begin
          payload_left--;
        end
      end
    end else if (eos) begin
      push_verdict(ST_CLOSED);
    end else if (c == CH_NL) begin
      finish_line();
    end else if (line_len + 1 >= LINE_LIMIT_DEF) begin
      push_verdict(ST_LINE_LONG);
    end else begin
      // bytes after a zero still count toward the line length
      line_len++;
      if (!text_done) begin
        if (c == CH_NUL) text_done = 1;
        else scan_text(c);
      end
    end
  endtask

  // stream building

  task automatic add_item(logic [7:0] b, logic eos);
    stream_item_t it;
    it.data = b;
    it.eos = eos;
    staged.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  task automatic add_line(string s);
    add_text(s);
    add_item(CH_NL, 1'b0);
  endtask

  task automatic add_payload(int n);
    repeat (n) add_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_eos();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic string count_text(int n);
    if ($urandom_range(0, 7) == 0) return {"00", $sformatf("%0d", n)};
    return $sformatf("%0d", n);
  endfunction

  task automatic add_frame(string tag, int n, int lim);
    add_line({tag, count_text(n)});
    add_payload((n > lim) ? $urandom_range(0, 3) : n);
  endtask

  function automatic int pick_len(int lim);
    int r;
    int cap;
    r = $urandom_range(0, 19);
    cap = (r == 0) ? 100 : (r < 4) ? 20 : 4;
    if (cap > lim) cap = lim;
    return (r == 0) ? cap : $urandom_range(0, cap);
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] b;
    if ($urandom_range(0, 2) != 0) return keyword_chars[$urandom_range(0, 11)];
    b = 8'($urandom_range(0, 255));
    return (b == CH_NL) ? CH_SPACE : b;
  endfunction

  // damage: 1 cut short by end of stream, 2 overwrite a byte, 3 insert a zero, 4 drop a byte
  task automatic flush_staged(int damage);
    int pos;
    stream_item_t nul_item;
    if (damage != 0 && staged.size() > 0) begin
      pos = $urandom_range(0, staged.size() - 1);
      case (damage)
        1: begin
          while (staged.size() > pos) void'(staged.pop_back());
          add_eos();
        end
        2: staged[pos].data = 8'($urandom_range(0, 255));
        3: begin
          nul_item.data = CH_NUL;
          nul_item.eos = 1'b0;
          staged.insert(pos, nul_item);
        end
        default: staged.delete(pos);
      endcase
    end
    foreach (staged[i]) stream_bytes.push_back(staged[i]);
    bytes_queued += staged.size();
    staged.delete();
  endtask

  task automatic add_random_request();
    int id_n;
    int argc;
    int nargs;
    int max_argc;
    int n;
    int flaw;
    bit with_id;
    bit id_late;
    bit argc_bad;
    flaw = $urandom_range(0, 11);
    with_id = ($urandom_range(0, 4) != 0);
    id_late = ($urandom_range(0, 4) == 0);
    id_n = pick_len(id_lim);
    if ($urandom_range(0, 19) == 0) id_n = id_lim + 1;
    max_argc = (argc_lim < MAX_ARGS - 1) ? argc_lim : MAX_ARGS - 1;
    argc_bad = (max_argc == 0) || ($urandom_range(0, 19) == 0);
    if (argc_bad) argc = $urandom_range(0, 1) ? 0 : max_argc + 1;
    else if ($urandom_range(0, 9) == 0) argc = $urandom_range(1, max_argc);
    else argc = $urandom_range(1, (max_argc < 4) ? max_argc : 4);
    nargs = argc_bad ? 1 : argc;
    case ($urandom_range(0, 15))
      0: nargs++;
      1: if (nargs > 0) nargs--;
      default: ;
    endcase
    if (with_id && !id_late) add_frame("ID ", id_n, id_lim);
    if ($urandom_range(0, 19) != 0) add_line({"ARGC ", count_text(argc)});
    if (with_id && id_late) add_frame("ID ", id_n, id_lim);
    for (int i = 0; i < nargs; i++) begin
      n = pick_len(arg_lim);
      if ($urandom_range(0, 29) == 0) n = arg_lim + 1;
      add_frame("ARG ", n, arg_lim);
    end
    case ($urandom_range(0, 19))
      0: ;
      1: begin
        add_text("END");
        add_item(CH_NUL, 1'b0);
        add_line("x");
      end
      default: add_line("END");
    endcase
    if ($urandom_range(0, 19) == 0) add_eos();
    flush_staged((flaw > 7) ? flaw - 7 : 0);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || in_valid || frame_results_due.size() != 0);
    // lines without a result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(int budget);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        add_random_request();
      end else if (pick < 19) begin
        repeat ($urandom_range(0, 10)) add_item(pick_char(), 1'b0);
        add_item(CH_NL, 1'b0);
        flush_staged(0);
      end else begin
        repeat ($urandom_range(LINE_LIMIT_DEF - 2, LINE_LIMIT_DEF + 1)) add_item(pick_char(), 1'b0);
        add_item(CH_NL, 1'b0);
        flush_staged(0);
      end
    end
    wait_idle();
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(v);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic write_limits(int id_v, int arg_v, int argc_v);
    set_reg(REG_ID_LIMIT, id_v);
    set_reg(REG_ARG_LIMIT, arg_v);
    set_reg(REG_ARGC_LIMIT, argc_v);
    id_lim = 8'(id_v);
    arg_lim = 16'(arg_v);
    argc_lim = 6'(argc_v);
  endtask

  // input side: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin : drive_stream
    stream_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // hold the offered byte until its transfer
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (stream_bytes.size() != 0) begin
      it = stream_bytes.pop_front();
      in_valid <= 1'b1;
      in_data_byte <= it.data;
      in_end_of_stream <= it.eos;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        gap_left = $urandom_range(0, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output side: stall pattern in segments, plus long hold-offs on request
  int hold_left = 0;
  int stalls_served = 0;
  int seg_left = 0;
  int seg_mode = 0;
  always @(negedge clk) begin
    if (stalls_served != stall_requests) begin
      stalls_served = stall_requests;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(4, 60);
      end
      seg_left--;
      case (seg_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : watch_results
    frame_result_t want;
    in_xfer <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) parse_stream_item(in_data_byte, in_end_of_stream);
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: kind %0d status %0d",
                                    out_kind, out_status));
        end else begin
          want = frame_results_due.pop_front();
          if (out_kind !== want.kind || out_arg_index !== want.idx ||
              out_frame_length !== want.flen || out_payload_byte !== want.pbyte ||
              out_last_of_frame !== want.last || out_status !== want.status) begin
            report_mismatch($sformatf(
              "got kind %0d idx %0d len %0d byte %02h last %0d st %0d, want %0d %0d %0d %02h %0d %0d",
              out_kind, out_arg_index, out_frame_length, out_payload_byte, out_last_of_frame,
              out_status, want.kind, want.idx, want.flen, want.pbyte, want.last, want.status));
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    id_lim = ID_LIMIT_RST;
    arg_lim = ARG_LIMIT_RST;
    argc_lim = ARGC_LIMIT_RST;
    clear_request();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed cases on the reset limits
    add_line("ID 3");
    add_payload(3);
    add_line("ARGC 2");
    add_line("ARG 0");
    add_line("ARG 2");
    add_payload(2);
    add_line("END");
    add_line("ID 2");
    add_item(CH_NL, 1'b0);
    add_item(CH_NUL, 1'b0);
    add_line("ARGC 1");
    add_line("ARG 1");
    add_item(8'hFF, 1'b0);
    add_line("END");
    add_eos();
    add_line("ID 64");
    add_payload(64);
    add_line("ID 65");
    add_line("ID ");
    add_line("ID 1x");
    add_line("ID 99999999");
    add_line("ID 5");
    add_payload(2);
    add_eos();
    add_line("ARGC 1");
    add_line("ARGC 1");
    add_line("ARGC 0");
    add_line("ARGC 64");
    add_line("ARG 1");
    add_line("ARGC 1");
    add_line("ARG 0");
    add_line("ARG 0");
    add_line("ARGC 1");
    add_line("ARG 4097");
    add_line("ARGC 1");
    add_line("ARG 3");
    add_payload(1);
    add_eos();
    add_line("");
    add_line("ENDX");
    add_text("END");
    add_item(CH_NUL, 1'b0);
    add_line("zz");
    add_line("END");
    add_line("ARGC 2");
    add_line("ARG 0");
    add_line("END");
    // longest line that still fits, then one byte too many
    repeat (LINE_LIMIT_DEF - 1) add_item(CH_A, 1'b0);
    add_item(CH_NL, 1'b0);
    repeat (LINE_LIMIT_DEF) add_item(CH_A, 1'b0);
    flush_staged(0);
    wait_idle();
    random_phase(100);

    // widest limits, with the receiver holding off to back up the input
    write_limits(255, 65535, 63);
    add_line("ID 255");
    add_payload(255);
    add_line("ARGC 63");
    repeat (63) add_line("ARG 0");
    add_line("END");
    add_line("ID 256");
    add_line("ARGC 1");
    add_line("ARG 65535");
    add_payload(3);
    add_eos();
    flush_staged(0);
    stall_requests++;
    random_phase(150);

    // narrowest limits
    write_limits(0, 0, 1);
    add_line("ID 0");
    add_line("ARGC 1");
    add_line("ARG 0");
    add_line("END");
    add_line("ID 1");
    add_line("ARGC 2");
    add_line("ARGC 1");
    add_line("ARG 1");
    flush_staged(0);
    wait_idle();
    random_phase(80);

    // a zero count limit refuses every count line
    write_limits(64, 4096, 0);
    add_line("ARGC 1");
    flush_staged(0);
    random_phase(40);

    for (int p = 0; p < 4; p++) begin
      write_limits($urandom_range(0, 255),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                   $urandom_range(1, 63));
      if (p == 1) stall_requests++;
      random_phase(100);
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rfp_pkg.sv
design/request_frame_parser_unit.sv
tb/tb.sv
